[hw/rtl/sync_crc16_frame_receiver_top_assert.svh]
// ----------------------------------------------------------------------------
// sync crc16 frame receiver assertion macros
// concurrent assertion wrappers shared by the receiver rtl, compiled out by
// ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef SYNC_CRC16_FRAME_RECEIVER_TOP_ASSERT_SVH
`define SYNC_CRC16_FRAME_RECEIVER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define SCFR_ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);
`define SCFR_ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`else
`define SCFR_ASSERT_ALWAYS(lbl, clk, rstn, expr, msg)
`define SCFR_ASSERT_PROP(lbl, clk, rstn, prop, msg)
`endif

`endif

[hw/rtl/scfr_pkg.sv]
// ----------------------------------------------------------------------------
// scfr_pkg
// types, constants and crc step function of the sync crc16 frame receiver
// ----------------------------------------------------------------------------
package scfr_pkg;

  localparam int unsigned DEF_FRAME_BYTES = 24;
  localparam int unsigned HDR_BYTES       = 2;
  localparam int unsigned TRAILER_BYTES   = 2;
  localparam int unsigned BITS_PER_BYTE   = 8;
  localparam int unsigned IDX_W           = 6;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  localparam logic [7:0] FIRST_SYNC_RST  = 8'hAA;
  localparam logic [7:0] SECOND_SYNC_RST = 8'h55;

  localparam int unsigned REG_IDX_W = 1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FIRST_SYNC  = 1'b0,
    REG_SECOND_SYNC = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    PH_HUNT1   = 2'd0,
    PH_HUNT2   = 2'd1,
    PH_COLLECT = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_EMIT_RD = 2'd1,
    ST_EMIT_WR = 2'd2,
    ST_ERR     = 2'd3
  } state_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       resync;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]       payload_byte;
    logic [IDX_W-1:0] byte_index;
    logic             last_of_frame;
    logic             frame_status;
  } out_beat_t;

  function automatic logic [15:0] crc_step(input logic [15:0] c);
    logic [15:0] sh;
    sh = {c[14:0], 1'b0};
    if ((c & CRC_TOP) != 16'h0000) begin
      crc_step = sh ^ CRC_POLY;
    end else begin
      crc_step = sh;
    end
  endfunction

endpackage

[hw/rtl/scfr_crc.sv]
// ----------------------------------------------------------------------------
// scfr_crc
// bit-serial crc-16 unit, one polynomial step per cycle, holds running crc
// ----------------------------------------------------------------------------
`include "sync_crc16_frame_receiver_top_assert.svh"

module scfr_crc import scfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        init_i,
  input  logic        start_i,
  input  logic [7:0]  data_i,
  output logic        busy_o,
  output logic [15:0] crc_o
);

  localparam int unsigned CNT_W = $clog2(BITS_PER_BYTE);

  logic [15:0]      crc_q, crc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign busy_o = (cnt_q != '0);
  assign crc_o  = crc_q;

  always_comb begin
    crc_d = crc_q;
    cnt_d = cnt_q;
    if (init_i) begin
      crc_d = CRC_INIT;
      cnt_d = '0;
    end else if (start_i) begin
      // first step folds the byte in
      crc_d = crc_step(crc_q ^ {data_i, 8'h00});
      cnt_d = CNT_W'(BITS_PER_BYTE - 1);
    end else if (busy_o) begin
      crc_d = crc_step(crc_q);
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CRC_INIT;
      cnt_q <= '0;
    end else begin
      crc_q <= crc_d;
      cnt_q <= cnt_d;
    end
  end

  `SCFR_ASSERT_PROP(a_start_idle, clk_i, rst_ni, start_i |-> !busy_o, "crc start while busy")
  `SCFR_ASSERT_PROP(a_init_idle, clk_i, rst_ni, init_i |-> !busy_o, "crc init while busy")

endmodule

[hw/rtl/scfr_store.sv]
// ----------------------------------------------------------------------------
// scfr_store
// frame byte memory, one write and one registered read port
// ----------------------------------------------------------------------------
module scfr_store import scfr_pkg::*; #(
  parameter int unsigned DEPTH = DEF_FRAME_BYTES
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [7:0]               rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/sync_crc16_frame_receiver_top.sv]
// ----------------------------------------------------------------------------
// sync_crc16_frame_receiver_top
// sync hunting deframer with crc-16/ccitt-false check and payload readout
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid_i / in_stall_o carries one received byte per beat
//   plus a resync flag that drops any partial frame before the byte is used.
//   output channel out_valid_o / out_stall_i carries payload bytes of a frame
//   whose crc matched, last one marked, or a single error beat on mismatch.
//   config port writes the two sync bytes by index; the user writes them
//   only while idle, the block does not enforce this.
// input stall: a byte that runs through the crc holds the input while the
//   bit-serial crc unit does one polynomial step per cycle; others do not.
// readout: after the last frame byte is taken, each payload beat is a store
//   read (ST_EMIT_RD) then an output load (ST_EMIT_WR).
//   the input stays stalled while a frame is read out.
// reset: sync bytes return to 0xaa / 0x55, hunting restarts, crc is 0xffff.
//   the frame memory is not cleared.
// output stall: the output register holds its beat and readout pauses.
// ----------------------------------------------------------------------------
`include "sync_crc16_frame_receiver_top_assert.svh"

module sync_crc16_frame_receiver_top import scfr_pkg::*; #(
  parameter int unsigned FRAME_BYTES = DEF_FRAME_BYTES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_beat_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_beat_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]           cfg_wdata_i
);

  localparam int unsigned CNT_W  = $clog2(FRAME_BYTES + 1);
  localparam int unsigned ADDR_W = $clog2(FRAME_BYTES);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(FRAME_BYTES - 1);
  localparam logic [CNT_W-1:0] LO_CNT   = CNT_W'(FRAME_BYTES - TRAILER_BYTES);
  localparam logic [CNT_W-1:0] HDR_CNT  = CNT_W'(HDR_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX =
    IDX_W'(FRAME_BYTES - HDR_BYTES - TRAILER_BYTES - 1);

  state_e           state_q, state_d;
  phase_e           phase_q, phase_d, eff_phase;
  logic [CNT_W-1:0] count_q, count_d;
  logic [7:0]       crc_lo_q, crc_lo_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [7:0]       first_q, second_q;
  logic             out_valid_q, out_valid_d;
  out_beat_t        out_data_q, out_data_d;

  logic        in_accept, slot_free;
  logic        crc_init, crc_start, crc_busy;
  logic [15:0] crc_val;
  logic        st_we;
  logic [7:0]  rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic        frame_done, frame_good;
  logic        out_load;
  logic [7:0]  rx;

  assign rx         = in_data_i.rx_byte;
  assign in_stall_o = (state_q != ST_IDLE) || crc_busy;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign eff_phase  = in_data_i.resync ? PH_HUNT1 : phase_q;
  assign rd_addr    = ADDR_W'(idx_q) + ADDR_W'(HDR_BYTES);

  scfr_crc u_crc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .init_i  (crc_init),
    .start_i (crc_start),
    .data_i  (rx),
    .busy_o  (crc_busy),
    .crc_o   (crc_val)
  );

  scfr_store #(
    .DEPTH (FRAME_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i (rx),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // sync hunt and frame collection
  always_comb begin
    phase_d    = phase_q;
    count_d    = count_q;
    crc_lo_d   = crc_lo_q;
    crc_init   = 1'b0;
    crc_start  = 1'b0;
    st_we      = 1'b0;
    frame_done = 1'b0;
    frame_good = 1'b0;
    if (in_accept) begin
      case (eff_phase)
        PH_HUNT2: begin
          if (rx == second_q) begin
            phase_d  = PH_COLLECT;
            count_d  = HDR_CNT;
            crc_init = 1'b1;
          end else if (rx != first_q) begin
            phase_d  = PH_HUNT1;
            count_d  = '0;
            crc_init = 1'b1;
          end
        end
        PH_COLLECT: begin
          st_we = 1'b1;
          if (count_q < LO_CNT) begin
            crc_start = 1'b1;
          end
          if (count_q == LO_CNT) begin
            crc_lo_d = rx;
          end
          if (count_q == LAST_CNT) begin
            frame_done = 1'b1;
            frame_good = ({rx, crc_lo_q} == crc_val);
            phase_d    = PH_HUNT1;
            count_d    = '0;
            crc_init   = 1'b1;
          end else begin
            count_d = count_q + CNT_W'(1);
          end
        end
        default: begin
          crc_init = 1'b1;
          if (rx == first_q) begin
            phase_d = PH_HUNT2;
            count_d = CNT_W'(1);
          end else begin
            phase_d = PH_HUNT1;
            count_d = '0;
          end
        end
      endcase
    end
  end

  // readout sequencer, next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (frame_done) begin
          state_d = frame_good ? ST_EMIT_RD : ST_ERR;
        end
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (slot_free) begin
          state_d = (idx_q == LAST_IDX) ? ST_IDLE : ST_EMIT_RD;
        end
      end
      ST_ERR: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // readout sequencer, outputs
  always_comb begin
    out_load   = 1'b0;
    out_data_d = out_data_q;
    idx_d      = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (frame_done) begin
          idx_d = '0;
        end
      end
      ST_EMIT_WR: begin
        if (slot_free) begin
          out_load                 = 1'b1;
          out_data_d.payload_byte  = rd_data;
          out_data_d.byte_index    = idx_q;
          out_data_d.last_of_frame = (idx_q == LAST_IDX);
          out_data_d.frame_status  = 1'b0;
          idx_d                    = idx_q + IDX_W'(1);
        end
      end
      ST_ERR: begin
        if (slot_free) begin
          out_load                 = 1'b1;
          out_data_d.payload_byte  = 8'h00;
          out_data_d.byte_index    = '0;
          out_data_d.last_of_frame = 1'b1;
          out_data_d.frame_status  = 1'b1;
        end
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_HUNT1;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      first_q     <= FIRST_SYNC_RST;
      second_q    <= SECOND_SYNC_RST;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FIRST_SYNC:  first_q  <= cfg_wdata_i;
          REG_SECOND_SYNC: second_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    crc_lo_q <= crc_lo_d;
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `SCFR_ASSERT_ALWAYS(a_count_range, clk_i, rst_ni, count_q <= LAST_CNT, "byte count past frame")
  `SCFR_ASSERT_PROP(a_readout_crc_idle, clk_i, rst_ni, (state_q != ST_IDLE) |-> !crc_busy, "crc busy during readout")
  `SCFR_ASSERT_PROP(a_err_beat, clk_i, rst_ni, (state_q == ST_ERR && slot_free) |=> (out_valid_q && out_data_q.frame_status), "error beat not loaded")

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync crc16 frame receiver testbench
// streams sync-framed bytes into the receiver: good frames, frames with a
// corrupted bit, frames cut off by resync and loose noise, under several sync
// byte settings and random valid/stall gaps. every output beat is checked in
// order against a built-in model of the deframer and its crc-16 check.
// ----------------------------------------------------------------------------
module testbench;
  import scfr_pkg::*;

  localparam int unsigned CLK_PERIOD    = 8;
  localparam int unsigned FRAME_LEN     = DEF_FRAME_BYTES;
  localparam int unsigned PAYLOAD_LEN   = FRAME_LEN - HDR_BYTES - TRAILER_BYTES;
  localparam int unsigned RANDOM_ITEMS  = 240;
  localparam int unsigned PHASE_ITEMS   = RANDOM_ITEMS / 6;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES   = 1500;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef enum int unsigned {FK_GOOD, FK_BAD_CRC, FK_CUT, FK_NOISE} frame_kind_e;

  class frame_scoreboard;
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    phase_e      phase;
    logic [6:0]  taken;
    logic [15:0] crc;
    logic [7:0]  rx_bytes [FRAME_LEN];
    out_beat_t   payload_q [$];
    int unsigned errors;

    function new();
      sync_first  = FIRST_SYNC_RST;
      sync_second = SECOND_SYNC_RST;
      errors      = 0;
      restart();
    endfunction

    static function logic [15:0] ccitt_update(logic [15:0] c, logic [7:0] d);
      logic [15:0] r;
      int          k;
      r = c ^ {d, 8'h00};
      for (k = 0; k < 8; k++) begin
        r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
      end
      return r;
    endfunction

    function void restart();
      phase = PH_HUNT1;
      taken = '0;
      crc   = CRC_INIT;
    endfunction

    function void set_reg(reg_idx_e idx, logic [7:0] v);
      case (idx)
        REG_FIRST_SYNC: begin
          sync_first = v;
        end
        REG_SECOND_SYNC: begin
          sync_second = v;
        end
        default: begin
        end
      endcase
    endfunction

    function int unsigned pending();
      return payload_q.size();
    endfunction

    function void note_input(in_beat_t beat);
      logic [7:0]  b;
      logic [15:0] rx_crc;
      out_beat_t   o;
      int          i;
      b = beat.rx_byte;
      if (beat.resync) restart();
      if (phase == PH_HUNT2) begin
        if (b == sync_second) begin
          phase = PH_COLLECT;
          taken = 7'(HDR_BYTES);
          crc   = CRC_INIT;
        end else if (b != sync_first) begin
          restart();
        end
        return;
      end
      if (phase != PH_COLLECT) begin
        restart();
        if (b == sync_first) begin
          phase = PH_HUNT2;
          taken = 7'd1;
        end
        return;
      end
      if (taken < FRAME_LEN) rx_bytes[taken] = b;
      if (taken < FRAME_LEN - TRAILER_BYTES) crc = ccitt_update(crc, b);
      taken = taken + 7'd1;
      if (taken >= FRAME_LEN) begin
        rx_crc = {rx_bytes[FRAME_LEN-1], rx_bytes[FRAME_LEN-2]};
        if (rx_crc == crc) begin
          for (i = 0; i < PAYLOAD_LEN; i++) begin
            o.payload_byte  = rx_bytes[HDR_BYTES + i];
            o.byte_index    = i[IDX_W-1:0];
            o.last_of_frame = (i == PAYLOAD_LEN - 1);
            o.frame_status  = 1'b0;
            payload_q.push_back(o);
          end
        end else begin
          o.payload_byte  = 8'h00;
          o.byte_index    = '0;
          o.last_of_frame = 1'b1;
          o.frame_status  = 1'b1;
          payload_q.push_back(o);
        end
        restart();
      end
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t want;
      if (payload_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("unexpected beat: byte %02h index %0d last %0b status %0b",
                   got.payload_byte, got.byte_index, got.last_of_frame, got.frame_status);
        end
        return;
      end
      want = payload_q.pop_front();
      if (got.payload_byte !== want.payload_byte || got.byte_index !== want.byte_index ||
          got.last_of_frame !== want.last_of_frame ||
          got.frame_status !== want.frame_status) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("beat mismatch: expected byte %02h index %0d last %0b status %0b",
                   want.payload_byte, want.byte_index, want.last_of_frame, want.frame_status);
          $display("               got      byte %02h index %0d last %0b status %0b",
                   got.payload_byte, got.byte_index, got.last_of_frame, got.frame_status);
        end
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_beat_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_beat_t            out_data;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic [7:0]           cfg_wdata;

  frame_scoreboard sb;
  int unsigned     hold_off    = 0;
  int unsigned     sent_items  = 0;
  int unsigned     cycle_count = 0;
  bit              tx_calm     = 1'b1;
  bit              rx_calm     = 1'b1;

  sync_crc16_frame_receiver_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver side: random wait before each beat, plus a long hold-off on request
  initial begin : out_stall_gen
    int unsigned wait_left;
    bit          took;
    wait_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      took = out_valid && !out_stall;
      @(negedge clk);
      if (took) wait_left = rx_calm ? 0 : $urandom_range(0, 16);
      if (hold_off > 0) begin
        out_stall = 1'b1;
        hold_off--;
      end else begin
        out_stall = (wait_left > 0);
        if (wait_left > 0 && out_valid) wait_left--;
      end
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic rs);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data.rx_byte = b;
    in_data.resync  = rs;
    in_valid        = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(in_data);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [7:0] v);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic wait_results();
    in_valid = 1'b0;
    while (sb.pending() > 0) @(negedge clk);
  endtask

  task automatic set_syncs(input logic [7:0] first_b, input logic [7:0] second_b);
    wait_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(REG_FIRST_SYNC, first_b);
    write_reg(REG_SECOND_SYNC, second_b);
  endtask

  task automatic send_frame(input frame_kind_e kind, input bit corner_fill,
                            input int unsigned extra_first, input bit lead_resync);
    logic [7:0]  fr [FRAME_LEN];
    logic [15:0] c;
    int unsigned n;
    int unsigned pos;
    int unsigned i;
    if (kind == FK_NOISE) begin
      repeat ($urandom_range(1, 6)) send_beat(8'($urandom), $urandom_range(0, 9) == 0);
      return;
    end
    fr[0] = sb.sync_first;
    fr[1] = sb.sync_second;
    c = CRC_INIT;
    for (i = HDR_BYTES; i < FRAME_LEN - TRAILER_BYTES; i++) begin
      fr[i] = corner_fill ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom);
      c = frame_scoreboard::ccitt_update(c, fr[i]);
    end
    fr[FRAME_LEN-2] = c[7:0];
    fr[FRAME_LEN-1] = c[15:8];
    if (kind == FK_BAD_CRC) begin
      pos = $urandom_range(HDR_BYTES, FRAME_LEN - 1);
      fr[pos] = fr[pos] ^ (8'h01 << $urandom_range(0, 7));
    end
    n = (kind == FK_CUT) ? $urandom_range(1, FRAME_LEN - 1) : FRAME_LEN;
    if (sb.sync_first == sb.sync_second) extra_first = 0;
    send_beat(fr[0], lead_resync);
    repeat (extra_first) send_beat(fr[0], 1'b0);
    for (i = 1; i < n; i++) send_beat(fr[i], 1'b0);
    if (kind == FK_CUT) send_beat(8'($urandom), 1'b1);
  endtask

  task automatic random_traffic(input int unsigned quota);
    int unsigned start;
    int unsigned r;
    frame_kind_e kind;
    start = sent_items;
    while (sent_items - start < quota) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 19);
      if (r < 11) kind = FK_GOOD;
      else if (r < 14) kind = FK_BAD_CRC;
      else if (r < 17) kind = FK_CUT;
      else kind = FK_NOISE;
      send_frame(kind, $urandom_range(0, 9) == 0,
                 ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0,
                 $urandom_range(0, 4) == 0);
      if ($urandom_range(0, 7) == 0) wait_results();
    end
  endtask

  initial begin : stimulus
    sb        = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // stray byte after first sync, resync on a new header, repeated first byte
    send_beat(FIRST_SYNC_RST, 1'b0);
    send_beat(8'h13, 1'b0);
    send_beat(FIRST_SYNC_RST, 1'b1);
    send_frame(FK_GOOD, 1'b1, 1, 1'b0);

    rx_calm = 1'b0;
    random_traffic(PHASE_ITEMS);

    set_syncs(8'h00, 8'hFF);
    hold_off = HOLD_CYCLES;
    random_traffic(PHASE_ITEMS);

    set_syncs(8'hFF, 8'h00);
    random_traffic(PHASE_ITEMS);

    set_syncs(8'h3C, 8'h3C);
    rx_calm = 1'b1;
    random_traffic(PHASE_ITEMS);

    set_syncs(8'($urandom), 8'($urandom));
    rx_calm = 1'b0;
    random_traffic(PHASE_ITEMS);

    set_syncs(FIRST_SYNC_RST, SECOND_SYNC_RST);
    random_traffic(PHASE_ITEMS);

    wait_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
